// ----- hw/rtl/pac_pkg.sv -----
// Shared types and constants of the polar angle CORDIC pipeline.
package pac_pkg;

  localparam int GUARD_BITS = 24;
  localparam int TABLE_LEN  = 24;
  localparam int ZW         = 33;
  localparam int ANGLE_W    = 16;

  localparam logic [ANGLE_W-1:0] ANGLE_ZERO        = 16'd0;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q13       = 16'd12868;
  localparam logic [ANGLE_W-1:0] PI_Q13            = 16'd25736;
  localparam logic [ANGLE_W-1:0] THREE_HALF_PI_Q13 = 16'd38604;
  localparam logic [ANGLE_W:0]   TWO_PI_Q13        = 17'd51472;

  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'h3243F6A9, 30'h1DAC6705, 30'h0FADBAFD, 30'h07F56EA7,
    30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
    30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
    30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef struct packed {
    logic               origin;
    logic               axis;
    logic [ANGLE_W-1:0] axis_angle;
    logic               x_neg;
    logic               y_neg;
  } tag_t;

endpackage

// ----- hw/rtl/pac_in_if.sv -----
// Input request channel carrying one point.
interface pac_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

// ----- hw/rtl/pac_out_if.sv -----
// Result request channel carrying one polar angle.
interface pac_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle;
  logic        at_origin;

  modport source (output valid, output angle, output at_origin, input ready);
  modport sink (input valid, input angle, input at_origin, output ready);
endinterface

// ----- hw/rtl/pac_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation stage with its own valid/ready register.
module pac_cordic_cell #(
  parameter int DW    = 42,
  parameter int SHIFT = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [DW-1:0]     x_i,
  input  logic signed [DW-1:0]     y_i,
  input  logic signed [pac_pkg::ZW-1:0] z_i,
  input  pac_pkg::tag_t            tag_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [DW-1:0]     x_o,
  output logic signed [DW-1:0]     y_o,
  output logic signed [pac_pkg::ZW-1:0] z_o,
  output pac_pkg::tag_t            tag_o
);
  import pac_pkg::*;

  logic                 valid_r;
  logic signed [DW-1:0] x_r, x_nxt;
  logic signed [DW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  tag_t                 tag_r;
  logic signed [DW-1:0] dx, dy;
  logic signed [ZW-1:0] step;

  assign ready_o = !valid_r || ready_i;
  assign dx      = y_i >>> SHIFT;
  assign dy      = x_i >>> SHIFT;
  assign step    = signed'({{(ZW-30){1'b0}}, ATAN_Q30[SHIFT]});

  always_comb begin
    if (!y_i[DW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + step;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= tag_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign tag_o   = tag_r;
endmodule

// ----- hw/rtl/pac_post.sv -----
// Output stage: rounds the angle, restores the quadrant (or takes the exact axis angle) and holds the result.
module pac_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [pac_pkg::ZW-1:0] z_i,
  input  pac_pkg::tag_t                 tag_i,
  pac_out_if.source                     out_ch
);
  import pac_pkg::*;

  logic               valid_r;
  logic [ANGLE_W-1:0] angle_r, angle_nxt;
  logic               origin_r;
  logic [ZW-2:0]      z_clamp;
  logic [ZW-1:0]      z_round;
  logic [ANGLE_W:0]   phi;
  logic [ANGLE_W:0]   ang;
  logic [ANGLE_W:0]   ang_wrap;

  assign ready_o = !valid_r || out_ch.ready;
  assign z_clamp = z_i[ZW-1] ? '0 : z_i[ZW-2:0];
  assign z_round = {1'b0, z_clamp} + ZW'(65536);
  assign phi     = (ANGLE_W+1)'(z_round[ZW-1:17]);

  always_comb begin
    if (!tag_i.x_neg && !tag_i.y_neg) begin
      ang = phi;
    end else if (tag_i.x_neg && !tag_i.y_neg) begin
      ang = {1'b0, PI_Q13} - phi;
    end else if (tag_i.x_neg) begin
      ang = {1'b0, PI_Q13} + phi;
    end else begin
      ang = TWO_PI_Q13 - phi;
    end
    ang_wrap = (ang >= TWO_PI_Q13) ? ang - TWO_PI_Q13 : ang;
    if (tag_i.origin) begin
      angle_nxt = ANGLE_ZERO;
    end else if (tag_i.axis) begin
      angle_nxt = tag_i.axis_angle;
    end else begin
      angle_nxt = ang_wrap[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      angle_r  <= angle_nxt;
      origin_r <= tag_i.origin;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.angle     = angle_r;
  assign out_ch.at_origin = origin_r;
endmodule

// ----- hw/rtl/polar_angle_full_turn_unit.sv -----
// Top level: pipelined vectoring CORDIC giving the polar angle of a point.
//
//   channel | direction | payload                      | handshake
//   in_ch   | sink      | coord_x, coord_y (signed)    | valid/ready
//   out_ch  | source     | angle (Q3.13), at_origin     | valid/ready
//
// One request is taken every cycle while the output side is ready; each passes through
// the input register, one CORDIC cell per iteration (at most 24) and the output register.
// Every stage has its own valid bit, so bubbles close up under a stalled output.
// Reset clears only the valid bits; payload registers are not reset.
module polar_angle_full_turn_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pac_in_if.sink     in_ch,
  pac_out_if.source  out_ch
);
  import pac_pkg::*;

  localparam int NCELL = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam int DW    = COORD_WIDTH + GUARD_BITS + 2;

  logic                 v   [NCELL+1];
  logic                 rdy [NCELL+1];
  logic signed [DW-1:0] xc  [NCELL+1];
  logic signed [DW-1:0] yc  [NCELL+1];
  logic signed [ZW-1:0] zc  [NCELL+1];
  tag_t                 tc  [NCELL+1];

  logic                          prep_valid_r;
  logic signed [DW-1:0]          prep_x_r, prep_x_nxt;
  logic signed [DW-1:0]          prep_y_r, prep_y_nxt;
  tag_t                          prep_tag_r, prep_tag_nxt;
  logic signed [COORD_WIDTH:0]   xs, ys;
  logic signed [COORD_WIDTH:0]   ax, ay;
  logic                          x_zero, y_zero;

  assign xs     = {in_ch.coord_x[COORD_WIDTH-1], in_ch.coord_x};
  assign ys     = {in_ch.coord_y[COORD_WIDTH-1], in_ch.coord_y};
  assign ax     = xs[COORD_WIDTH] ? -xs : xs;
  assign ay     = ys[COORD_WIDTH] ? -ys : ys;
  assign x_zero = (in_ch.coord_x == '0);
  assign y_zero = (in_ch.coord_y == '0);

  always_comb begin
    prep_x_nxt         = {1'b0, ax, {GUARD_BITS{1'b0}}};
    prep_y_nxt         = {1'b0, ay, {GUARD_BITS{1'b0}}};
    prep_tag_nxt.origin = x_zero && y_zero;
    prep_tag_nxt.axis   = x_zero || y_zero;
    prep_tag_nxt.x_neg  = xs[COORD_WIDTH];
    prep_tag_nxt.y_neg  = ys[COORD_WIDTH];
    if (x_zero) begin
      prep_tag_nxt.axis_angle = ys[COORD_WIDTH] ? THREE_HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      prep_tag_nxt.axis_angle = xs[COORD_WIDTH] ? PI_Q13 : ANGLE_ZERO;
    end
  end

  assign in_ch.ready = !prep_valid_r || rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      prep_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      prep_x_r   <= prep_x_nxt;
      prep_y_r   <= prep_y_nxt;
      prep_tag_r <= prep_tag_nxt;
    end
  end

  assign v[0]  = prep_valid_r;
  assign xc[0] = prep_x_r;
  assign yc[0] = prep_y_r;
  assign zc[0] = '0;
  assign tc[0] = prep_tag_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pac_cordic_cell #(
      .DW    (DW),
      .SHIFT (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v[i]),
      .ready_o (rdy[i]),
      .x_i     (xc[i]),
      .y_i     (yc[i]),
      .z_i     (zc[i]),
      .tag_i   (tc[i]),
      .valid_o (v[i+1]),
      .ready_i (rdy[i+1]),
      .x_o     (xc[i+1]),
      .y_o     (yc[i+1]),
      .z_o     (zc[i+1]),
      .tag_o   (tc[i+1])
    );
  end

  pac_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v[NCELL]),
    .ready_o (rdy[NCELL]),
    .z_i     (zc[NCELL]),
    .tag_i   (tc[NCELL]),
    .out_ch  (out_ch)
  );

  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.at_origin |-> out_ch.angle == ANGLE_ZERO)
    else $error("origin result carries a nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> {1'b0, out_ch.angle} < TWO_PI_Q13)
    else $error("angle outside one full turn");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while the output side takes every result");
endmodule

// ----- bench/polar_angle_full_turn_unit_tb.sv -----
// Testbench for the polar angle CORDIC unit: random and edge-case points against a predictor.
`timescale 1ns / 1ps

module polar_angle_full_turn_unit_tb;

  localparam int COORD_WIDTH = 16;
  localparam int ITERATIONS  = 16;
  localparam int STAGES      = (ITERATIONS < 24) ? ITERATIONS : 24;
  localparam int LATENCY     = STAGES + 2;
  localparam int SHIFT_GUARD = 24;
  localparam int RANDOM_POINTS = 1080;
  localparam longint CYCLE_LIMIT = 400000;

  localparam int unsigned ANG_HALF_PI   = 12868;
  localparam int unsigned ANG_PI        = 25736;
  localparam int unsigned ANG_3_HALF_PI = 38604;
  localparam int unsigned ANG_TWO_PI    = 51472;

  localparam longint ARCTAN_STEP [24] = '{
    'h3243F6A9, 'h1DAC6705, 'h0FADBAFD, 'h07F56EA7,
    'h03FEAB76, 'h01FFD55B, 'h00FFFAAA, 'h007FFF55,
    'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF,
    'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
    'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
  };

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } point_t;

  typedef struct {
    point_t      pt;
    logic [15:0] angle;
    logic        at_origin;
  } polar_result_t;

  logic clk;
  logic rst_n;

  pac_in_if #(.COORD_WIDTH(COORD_WIDTH)) in_ch ();
  pac_out_if out_ch ();

  polar_angle_full_turn_unit #(
    .COORD_WIDTH(COORD_WIDTH),
    .ITERATIONS (ITERATIONS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  point_t        points_to_send[$];
  polar_result_t angles_due[$];

  int     mismatches;
  int     points_sent;
  int     angles_checked;
  int     origin_seen;
  int     axis_seen;
  int     quadrant_seen [4];
  int     wraps_seen;
  int     send_gap;
  int     recv_stall;
  longint cycle_count;

  function automatic polar_result_t predict_polar_angle(point_t p);
    polar_result_t r;
    longint x, y, ax, ay, cx, cy, z, dx, dy;
    int unsigned phi, ang;
    r.pt = p;
    r.angle = '0;
    r.at_origin = 1'b0;
    x = p.x;
    y = p.y;
    if (x == 0 && y == 0) begin
      r.at_origin = 1'b1;
    end else if (x == 0) begin
      r.angle = (y > 0) ? ANG_HALF_PI[15:0] : ANG_3_HALF_PI[15:0];
    end else if (y == 0) begin
      r.angle = (x > 0) ? 16'd0 : ANG_PI[15:0];
    end else begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      cx = ax <<< SHIFT_GUARD;
      cy = ay <<< SHIFT_GUARD;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ARCTAN_STEP[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ARCTAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      phi = int'((z + 65536) >>> 17);
      if (x > 0 && y > 0) ang = phi;
      else if (x < 0 && y > 0) ang = ANG_PI - phi;
      else if (x < 0) ang = ANG_PI + phi;
      else ang = ANG_TWO_PI - phi;
      if (ang >= ANG_TWO_PI) ang = ang - ANG_TWO_PI;
      r.angle = ang[15:0];
    end
    return r;
  endfunction

  task automatic add_point(int x, int y);
    point_t p;
    p.x = x[COORD_WIDTH-1:0];
    p.y = y[COORD_WIDTH-1:0];
    points_to_send.push_back(p);
  endtask

  function automatic int pick_extreme();
    int vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
    return vals[$urandom_range(0, 5)];
  endfunction

  function automatic int signed_small(int m);
    return $urandom_range(0, 2 * m) - m;
  endfunction

  function automatic int full_coord();
    return int'($signed(16'($urandom)));
  endfunction

  task automatic add_random_point();
    int kind, a, b, s;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      add_point(full_coord(), full_coord());
    end else if (kind < 55) begin
      add_point(signed_small(4), signed_small(4));
    end else if (kind < 65) begin
      if ($urandom_range(0, 1)) add_point(0, full_coord());
      else add_point(full_coord(), 0);
    end else if (kind < 80) begin
      a = full_coord();
      b = signed_small(3);
      if ($urandom_range(0, 1)) add_point(a, b);
      else add_point(b, a);
    end else if (kind < 90) begin
      a = $urandom_range(1, 32767);
      s = $urandom_range(0, 3);
      add_point((s & 1) ? -a : a, (s & 2) ? -a : a);
    end else begin
      add_point(pick_extreme(), pick_extreme());
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d angles still due", cycle_count,
               angles_due.size());
      $display("polar_angle_full_turn_unit_tb: done, errors");
      $finish;
    end
  end

  // Driver: holds a request until it is taken, then may wait a randomly drawn gap before the next.
  always @(posedge clk) begin
    polar_result_t exp_r;
    point_t        next_pt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      in_ch.valid <= 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        exp_r.pt.x = in_ch.coord_x;
        exp_r.pt.y = in_ch.coord_y;
        exp_r = predict_polar_angle(exp_r.pt);
        angles_due.push_back(exp_r);
        points_sent++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (points_to_send.size() != 0) begin
        next_pt = points_to_send.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.coord_x <= next_pt.x;
        in_ch.coord_y <= next_pt.y;
        send_gap <= (((points_sent / 60) % 4) == 2) ? 0 : $urandom_range(0, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each returned angle with the oldest one due.
  always @(posedge clk) begin
    polar_result_t exp_r;
    int            n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (angles_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: angle %0d at_origin %0b", out_ch.angle,
                     out_ch.at_origin);
        end else begin
          exp_r = angles_due.pop_front();
          angles_checked++;
          if (exp_r.at_origin) origin_seen++;
          else if (exp_r.pt.x == 0 || exp_r.pt.y == 0) axis_seen++;
          else quadrant_seen[{exp_r.pt.y < 0, (exp_r.pt.x < 0) ^ (exp_r.pt.y < 0)}]++;
          if (exp_r.pt.x > 0 && exp_r.pt.y < 0 && exp_r.angle == 16'd0) wraps_seen++;
          if (out_ch.angle !== exp_r.angle || out_ch.at_origin !== exp_r.at_origin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch (%0d, %0d): expected %0d/%0b, got %0d/%0b",
                       exp_r.pt.x, exp_r.pt.y, exp_r.angle, exp_r.at_origin,
                       out_ch.angle, out_ch.at_origin);
          end
        end
        n = (((angles_checked / 70) % 4) == 1) ? 0 : $urandom_range(0, 8);
        recv_stall <= n;
        out_ch.ready <= (n == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= (recv_stall == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    points_sent = 0;
    angles_checked = 0;
    origin_seen = 0;
    axis_seen = 0;
    quadrant_seen = '{0, 0, 0, 0};
    wraps_seen = 0;
    cycle_count = 0;

    add_point(0, 0);
    add_point(1, 0);
    add_point(0, 1);
    add_point(-1, 0);
    add_point(0, -1);
    add_point(32767, 0);
    add_point(0, 32767);
    add_point(-32768, 0);
    add_point(0, -32768);
    add_point(1, 1);
    add_point(-1, 1);
    add_point(-1, -1);
    add_point(1, -1);
    add_point(32767, 32767);
    add_point(-32768, 32767);
    add_point(-32768, -32768);
    add_point(32767, -32768);
    add_point(32767, -1);
    add_point(32767, 1);
    add_point(-32768, 1);
    add_point(-32768, -1);
    add_point(1, -32768);
    add_point(-1, 32767);
    for (int k = 0; k < RANDOM_POINTS; k++) add_random_point();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (points_to_send.size() != 0 || in_ch.valid) @(posedge clk);
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("checked %0d angles from %0d points: %0d origin, %0d on an axis",
             angles_checked, points_sent, origin_seen, axis_seen);
    $display("quadrants I..IV: %0d %0d %0d %0d, full-turn wraps to zero: %0d, mismatches: %0d",
             quadrant_seen[0], quadrant_seen[1], quadrant_seen[2], quadrant_seen[3],
             wraps_seen, mismatches);
    if (mismatches == 0) begin
      $display("polar_angle_full_turn_unit_tb: done, clean");
    end else begin
      $display("polar_angle_full_turn_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
